@@ hdl/nsc_pkg.sv @@
// Shared types and constants for the spoken-number clip sequencer.
package nsc_pkg;

	localparam int VALUE_W     = 24;
	localparam int DIGITS      = 7;
	localparam int BCD_W       = 4 * DIGITS;
	localparam int CLIP_W      = 4;
	localparam int MAX_CLIPS   = 11;
	localparam int PLACE_COUNT = 4;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [BCD_W-1:0]   bcd_t;
	typedef logic [CLIP_W-1:0]  clip_t;
	typedef logic [3:0]         clip_cnt_t;

	localparam value_t VALUE_MAX = 24'd9999999;

	localparam clip_t CLIP_ZERO          = 4'd1;
	localparam clip_t CLIP_TEN           = 4'd11;
	localparam clip_t CLIP_POINT         = 4'd12;
	localparam clip_t CLIP_HUNDRED       = 4'd13;
	localparam clip_t CLIP_THOUSAND      = 4'd14;
	localparam clip_t CLIP_TEN_THOUSAND  = 4'd15;

	// Place words for the four digits above the units digit, highest first.
	localparam clip_t PLACE_CLIP [PLACE_COUNT] = '{
		CLIP_TEN_THOUSAND, CLIP_THOUSAND, CLIP_HUNDRED, CLIP_TEN
	};

endpackage

@@ hdl/number_to_spoken_clip_sequence_unit.sv @@
// Top level of the spoken-number clip sequencer.
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+-------------------------------
//  command  | start, busy, scaled_value[23:0]        | word taken when start && !busy
//  result   | strobe, clip_number[3:0], last_clip    | one word per strobe cycle
//
// A command word runs through five register stages (saturate, three BCD conversion
// stages of eight bits each, clip list build) and then into a shift-out emitter.
// The emitter sends one clip per cycle and holds an item until its last clip (of 1 to
// 11) goes out; an item with nothing to speak passes through it as well. That emitter is
// what sets the sustained rate. The first clip then leaves through the output register.
// Reset clears all valid bits and the emitter count; no clearing pass is needed.
// The receiver cannot stall: backpressure comes only from the emitter, and busy
// rises when the stage-one register is full and cannot advance.
module number_to_spoken_clip_sequence_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  nsc_pkg::value_t scaled_value,
	output logic            strobe,
	output nsc_pkg::clip_t  clip_number,
	output logic            last_clip
);
	import nsc_pkg::*;

	// Converter handshake and output.
	logic  conv_rdy;
	logic  conv_vld;
	bcd_t  conv_bcd;

	// Clip list build stage.
	logic       vld_s5;
	clip_t      list_s5 [MAX_CLIPS];
	clip_cnt_t  len_s5;
	logic       rdy_s5;

	clip_t      list_d [MAX_CLIPS];
	clip_cnt_t  len_d;
	logic [3:0] dig;
	logic [3:0] prev_dig;

	// Emitter.
	clip_t      shl_q [MAX_CLIPS];
	clip_cnt_t  rem_q;
	logic       take;

	// Output register.
	logic       strobe_q;
	clip_t      clip_q;
	logic       last_q;

	nsc_bcd_pipe u_bcd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (start),
		.in_rdy   (conv_rdy),
		.in_value (scaled_value),
		.out_vld  (conv_vld),
		.out_rdy  (rdy_s5),
		.out_bcd  (conv_bcd)
	);

	assign busy = !conv_rdy;

	// Build the compacted clip list for one value. Digits from the top:
	// [27:24] ten-thousands, [23:20] thousands, [19:16] hundreds, [15:12] tens,
	// [11:8] units, [7:4] tenths; the hundredths digit is dropped.
	always_comb begin
		for (int k = 0; k < MAX_CLIPS; k++) begin
			list_d[k] = CLIP_ZERO;
		end
		len_d    = '0;
		prev_dig = '0;
		dig      = '0;
		for (int i = 0; i < PLACE_COUNT; i++) begin
			dig = conv_bcd[BCD_W-1-4*i -: 4];
			if (dig != 4'd0) begin
				list_d[len_d] = dig + 4'd1;
				len_d         = len_d + 4'd1;
				list_d[len_d] = PLACE_CLIP[i];
				len_d         = len_d + 4'd1;
			end else if (prev_dig != 4'd0) begin
				// A zero is spoken only right under a nonzero digit.
				list_d[len_d] = CLIP_ZERO;
				len_d         = len_d + 4'd1;
			end
			prev_dig = dig;
		end
		// Units digit is spoken bare.
		if (conv_bcd[11:8] != 4'd0) begin
			list_d[len_d] = conv_bcd[11:8] + 4'd1;
			len_d         = len_d + 4'd1;
		end
		// Tenths digit follows the point word.
		if (conv_bcd[7:4] != 4'd0) begin
			list_d[len_d] = CLIP_POINT;
			len_d         = len_d + 4'd1;
			list_d[len_d] = conv_bcd[7:4] + 4'd1;
			len_d         = len_d + 4'd1;
		end
		// Value zero speaks a single zero.
		if (conv_bcd == '0) begin
			list_d[0] = CLIP_ZERO;
			len_d     = 4'd1;
		end
	end

	// Emitter takes a new list when idle or while its last clip goes out.
	assign take   = vld_s5 && (rem_q <= 4'd1);
	assign rdy_s5 = !vld_s5 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5   <= 1'b0;
			rem_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (rdy_s5) vld_s5 <= conv_vld;
			// Emit the head clip whenever the emitter holds one.
			strobe_q <= (rem_q != 4'd0);
			last_q   <= (rem_q == 4'd1);
			if (take) begin
				rem_q <= len_s5;
			end else if (rem_q != 4'd0) begin
				rem_q <= rem_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5 && conv_vld) begin
			list_s5 <= list_d;
			len_s5  <= len_d;
		end
		clip_q <= shl_q[0];
		if (take) begin
			shl_q <= list_s5;
		end else begin
			// Advance the list by one clip.
			for (int k = 0; k < MAX_CLIPS - 1; k++) begin
				shl_q[k] <= shl_q[k+1];
			end
			shl_q[MAX_CLIPS-1] <= CLIP_ZERO;
		end
	end

	assign strobe      = strobe_q;
	assign clip_number = clip_q;
	assign last_clip   = last_q;

endmodule

@@ hdl/nsc_bcd_pipe.sv @@
// Binary to BCD converter: saturating input stage and three shift-add-3 stages.
module nsc_bcd_pipe (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	output logic           in_rdy,
	input  nsc_pkg::value_t in_value,
	output logic           out_vld,
	input  logic           out_rdy,
	output nsc_pkg::bcd_t  out_bcd
);
	import nsc_pkg::*;

	// Eight shift-add-3 steps: adjust every digit, then shift in one bit.
	function automatic bcd_t dd8(input bcd_t bcd_in, input logic [7:0] bits);
		bcd_t b;
		b = bcd_in;
		for (int s = 7; s >= 0; s--) begin
			for (int k = 0; k < DIGITS; k++) begin
				if (b[4*k +: 4] >= 4'd5) begin
					b[4*k +: 4] = b[4*k +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], bits[s]};
		end
		return b;
	endfunction

	logic           vld_s1, vld_s2, vld_s3, vld_s4;
	value_t         v_s1;
	bcd_t           bcd_s2, bcd_s3, bcd_s4;
	logic [15:0]    low_s2;
	logic [7:0]     low_s3;
	logic           rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	assign rdy_s4 = !vld_s4 || out_rdy;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_rdy = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_vld;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_vld) begin
			v_s1 <= (in_value > VALUE_MAX) ? VALUE_MAX : in_value;
		end
		if (rdy_s2 && vld_s1) begin
			bcd_s2 <= dd8('0, v_s1[23:16]);
			low_s2 <= v_s1[15:0];
		end
		if (rdy_s3 && vld_s2) begin
			bcd_s3 <= dd8(bcd_s2, low_s2[15:8]);
			low_s3 <= low_s2[7:0];
		end
		if (rdy_s4 && vld_s3) begin
			bcd_s4 <= dd8(bcd_s3, low_s3);
		end
	end

	assign out_vld = vld_s4;
	assign out_bcd = bcd_s4;

endmodule

@@ hdl/nsc_checker.sv @@
// Port-level checks for the spoken-number clip sequencer, bound to the top level.
module nsc_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input nsc_pkg::value_t scaled_value,
	input logic            strobe,
	input nsc_pkg::clip_t  clip_number,
	input logic            last_clip
);
	import nsc_pkg::*;

	// A command word and the busy flag are always known while start is up.
	a_command_known: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !$isunknown({busy, scaled_value}))
		else $error("unknown command word or busy");

	// A result word never marks the end without a strobe.
	a_last_needs_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last_clip |-> strobe)
		else $error("last_clip without strobe");

	// Clips of one value go out in consecutive cycles.
	a_burst_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_clip |=> strobe)
		else $error("gap inside a clip burst");

	// Two spoken zeros never follow each other within one value.
	a_no_double_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_clip && clip_number == CLIP_ZERO
		|=> !(strobe && clip_number == CLIP_ZERO))
		else $error("two zero clips in a row");

	// A place word always comes right after a nonzero digit clip.
	a_place_after_digit: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (clip_number == CLIP_TEN || clip_number == CLIP_HUNDRED ||
			clip_number == CLIP_THOUSAND || clip_number == CLIP_TEN_THOUSAND)
		|-> $past(strobe) && !$past(last_clip) && $past(clip_number) >= 4'd2 &&
			$past(clip_number) <= 4'd10)
		else $error("place word not preceded by a digit");

endmodule

bind number_to_spoken_clip_sequence_unit nsc_checker u_nsc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.scaled_value (scaled_value),
	.strobe       (strobe),
	.clip_number  (clip_number),
	.last_clip    (last_clip)
);

@@ dv/testbench.sv @@
// Self-checking testbench for the spoken-number clip sequencer.
`timescale 1ns / 1ps

module testbench;
	import nsc_pkg::*;

	// One spoken clip as the result port carries it.
	typedef struct packed {
		clip_t clip;
		logic  is_last;
	} clip_word_t;

	localparam int RANDOM_ITEMS  = 460;
	localparam int IDLE_PERCENT  = 34;
	localparam int CALM_FIRST    = 150;   // first command word of the stretch sent with no idling
	localparam int CALM_LAST     = 230;
	localparam int DRAIN_CYCLES  = 24;    // wait for stray clips after the last owed one

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	value_t scaled_value;
	logic   strobe;
	clip_t  clip_number;
	logic   last_clip;

	value_t     command_queue[$];   // values waiting to be driven
	clip_word_t spoken_clips[$];    // clips owed by the block, oldest first
	logic       word_taken;
	int         words_sent;
	int         words_taken;
	int         clips_checked;
	int         silent_values;
	int         clamped_values;
	int         fail_count;

	number_to_spoken_clip_sequence_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.scaled_value (scaled_value),
		.strobe       (strobe),
		.clip_number  (clip_number),
		.last_clip    (last_clip)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Work out the clips that one command word must produce and queue them.
	// Digits from ten-thousands down to tens carry a place word; a zero digit
	// is spoken only right under a nonzero one; units are bare; a nonzero
	// tenths digit follows "point"; hundredths never speak.
	function automatic void speak_value(value_t raw);
		int unsigned v;
		int unsigned digit;
		int unsigned above;
		int unsigned divisor;
		clip_word_t  said[$];
		v     = 32'((raw > VALUE_MAX) ? VALUE_MAX : raw);
		above = 0;
		if (raw > VALUE_MAX)
			clamped_values++;
		if (v == 0) begin
			spoken_clips.push_back('{clip: CLIP_ZERO, is_last: 1'b1});
			return;
		end
		divisor = 1000000;
		for (int p = 0; p < PLACE_COUNT; p++) begin
			digit = (v / divisor) % 10;
			if (digit != 0) begin
				said.push_back('{clip: clip_t'(digit + 1), is_last: 1'b0});
				said.push_back('{clip: PLACE_CLIP[p], is_last: 1'b0});
			end else if (above != 0) begin
				said.push_back('{clip: CLIP_ZERO, is_last: 1'b0});
			end
			above   = digit;
			divisor = divisor / 10;
		end
		digit = (v / 100) % 10;
		if (digit != 0)
			said.push_back('{clip: clip_t'(digit + 1), is_last: 1'b0});
		digit = (v / 10) % 10;
		if (digit != 0) begin
			said.push_back('{clip: CLIP_POINT, is_last: 1'b0});
			said.push_back('{clip: clip_t'(digit + 1), is_last: 1'b0});
		end
		if (said.size() == 0) begin
			silent_values++;
			return;
		end
		said[said.size() - 1].is_last = 1'b1;
		foreach (said[k])
			spoken_clips.push_back(said[k]);
	endfunction

	// Random value shaped to hit zero runs: mostly digit by digit with many
	// zeros, some tiny values, some raw 24-bit words that exercise the clamp.
	function automatic value_t random_value();
		int unsigned pick;
		int unsigned v;
		int unsigned digit;
		pick = $urandom_range(99);
		if (pick < 10)
			return value_t'($urandom);
		if (pick < 20)
			return value_t'($urandom_range(99));
		v = 0;
		for (int k = 0; k < DIGITS; k++) begin
			digit = ($urandom_range(99) < 40) ? 0 : $urandom_range(9);
			v = v * 10 + digit;
		end
		return value_t'(v);
	endfunction

	// Note acceptance at the rising edge and predict right away; inputs are
	// stable here since the driver only moves them at the falling edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_taken <= 1'b0;
		end else begin
			word_taken <= start && !busy;
			if (start && !busy) begin
				speak_value(scaled_value);
				words_taken++;
			end
		end
	end

	// Driver: advance to the next word once the current one is taken, hold
	// it while busy, and idle at random outside the calm stretch. Idle cycles
	// put noise on the value port.
	always @(negedge clk) begin
		if (arst_n && (!start || word_taken)) begin
			if (command_queue.size() > 0 &&
			    ((words_sent >= CALM_FIRST && words_sent < CALM_LAST) ||
			     $urandom_range(99) >= IDLE_PERCENT)) begin
				start        <= 1'b1;
				scaled_value <= command_queue.pop_front();
				words_sent++;
			end else begin
				start        <= 1'b0;
				scaled_value <= value_t'($urandom);
			end
		end
	end

	// Monitor: every strobe must match the oldest clip still owed.
	always @(posedge clk) begin
		clip_word_t want;
		if (arst_n && strobe) begin
			if (spoken_clips.size() == 0) begin
				$error("unexpected clip word: clip_number %0d last_clip %0b",
				       clip_number, last_clip);
				fail_count++;
			end else begin
				want = spoken_clips.pop_front();
				clips_checked++;
				if (clip_number !== want.clip) begin
					$error("clip_number: expected %0d, actual %0d", want.clip, clip_number);
					fail_count++;
				end
				if (last_clip !== want.is_last) begin
					$error("last_clip: expected %0b, actual %0b", want.is_last, last_clip);
					fail_count++;
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		value_t directed[$];
		int     total_words;
		words_sent     = 0;
		words_taken    = 0;
		clips_checked  = 0;
		silent_values  = 0;
		clamped_values = 0;
		fail_count     = 0;
		start          = 1'b0;
		scaled_value   = '0;
		arst_n         = 1'b0;

		// Zero, hundredths only (silent), tenths only, trailing zeros under
		// a nonzero digit, inner zero runs, full range and clamped values.
		directed = '{
			24'd0, 24'd1, 24'd9, 24'd10, 24'd90, 24'd100, 24'd3000,
			24'd20000, 24'd100000, 24'd1000000, 24'd1000010, 24'd1010100,
			24'd101010, 24'd10010, 24'd9090909, 24'd5000050, 24'd1234567,
			24'd9999999, 24'd10000000, 24'hFFFFFF, 24'h800000, 24'd99,
			24'd990, 24'd9999900
		};
		foreach (directed[k])
			command_queue.push_back(directed[k]);
		repeat (RANDOM_ITEMS)
			command_queue.push_back(random_value());
		total_words = command_queue.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_taken < total_words)
			@(posedge clk);
		while (spoken_clips.size() != 0)
			@(posedge clk);
		// Let any stray clip out of the emitter before judging.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (spoken_clips.size() != 0) begin
			$error("%0d clips never arrived", spoken_clips.size());
			fail_count++;
		end

		$display("Spoke %0d command words as %0d clips checked.", words_taken, clips_checked);
		$display("Of those, %0d gave no clip and %0d were clamped to the top value.",
		         silent_values, clamped_values);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/nsc_pkg.sv
hdl/nsc_bcd_pipe.sv
hdl/number_to_spoken_clip_sequence_unit.sv
hdl/nsc_checker.sv
dv/testbench.sv
